@@ rtl/core/lru_pkg.sv @@
// ----------------------------------------------------------------------------
// lru_pkg
// Shared sizes, types and helpers for the LRU list pool manager.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int ENTRIES = 1024;
    localparam int ENTRY_W = $clog2(ENTRIES);
    localparam int LINK_W  = $clog2(ENTRIES + 1);
    localparam int IDX_W   = 10;
    localparam int FRONT_W = 10;
    localparam int COUNT_W = 32;

    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [LINK_W-1:0]  t_link;

    // the head sentinel sits one past the last entry
    localparam t_link SENTINEL = t_link'(ENTRIES);

    localparam logic OP_TOUCH = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_UNLINK,
        ST_LINK,
        ST_FRONT
    } t_state;

    typedef struct packed {
        logic   we;
        t_entry waddr;
        t_link  wdata;
        t_entry raddr;
    } t_ram_req;

    typedef struct packed {
        logic               valid;
        logic               alloc;
        logic [FRONT_W-1:0] front;
        t_link              head;
        t_link              tail;
    } t_ctrl_out;

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(ENTRIES);
    endfunction

    function automatic t_entry idx_to_entry(input logic [IDX_W-1:0] idx);
        logic [31:0] w;
        w = 32'(idx);
        return w[ENTRY_W-1:0];
    endfunction

    function automatic logic [FRONT_W-1:0] to_front(input t_link l);
        logic [31:0] w;
        w = 32'(l);
        return w[FRONT_W-1:0];
    endfunction

endpackage

@@ rtl/core/lru_link_ram.sv @@
// ----------------------------------------------------------------------------
// lru_link_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lru_link_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/lru_ctrl.sv @@
// ----------------------------------------------------------------------------
// lru_ctrl
// Sequencer for the link memories: initial chain fill, then per transaction
// read of the entry's links, unlink, relink at the front, where a move is needed.
// ----------------------------------------------------------------------------
module lru_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_opcode,
    input  logic [lru_pkg::IDX_W-1:0] i_entry_index,
    output logic                      o_in_ready,
    input  logic                      i_out_free,
    output lru_pkg::t_ctrl_out        o_ctrl,
    output lru_pkg::t_ram_req         o_next_req,
    output lru_pkg::t_ram_req         o_prev_req,
    input  lru_pkg::t_link            i_next_rdata,
    input  lru_pkg::t_link            i_prev_rdata
);
    import lru_pkg::*;

    t_state r_state, n_state;
    t_entry r_init_cnt, n_init_cnt;
    t_link  r_head, n_head;
    t_link  r_tail, n_tail;
    t_entry r_entry, n_entry;
    logic   r_alloc, n_alloc;
    logic   r_skip, n_skip;

    t_entry w_in_entry;
    logic   w_in_skip;
    logic   w_init_last;

    assign w_in_entry  = (i_opcode == OP_ALLOC) ? r_tail[ENTRY_W-1:0]
                                                : idx_to_entry(i_entry_index);
    assign w_in_skip   = (i_opcode == OP_TOUCH) && !idx_in_range(i_entry_index);
    assign w_init_last = (r_init_cnt == t_entry'(ENTRIES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (w_init_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = w_in_skip ? ST_FRONT : ST_UNLINK;
            end
            ST_UNLINK: begin
                // already at the front: nothing to move
                n_state = (i_prev_rdata == SENTINEL) ? ST_FRONT : ST_LINK;
            end
            ST_LINK: begin
                n_state = ST_FRONT;
            end
            ST_FRONT: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    // datapath and memory requests
    always_comb begin
        n_init_cnt = r_init_cnt;
        n_head     = r_head;
        n_tail     = r_tail;
        n_entry    = r_entry;
        n_alloc    = r_alloc;
        n_skip     = r_skip;

        o_next_req       = '0;
        o_prev_req       = '0;
        o_next_req.raddr = w_in_entry;
        o_prev_req.raddr = w_in_entry;

        case (r_state)
            ST_INIT: begin
                o_next_req.we    = 1'b1;
                o_next_req.waddr = r_init_cnt;
                o_next_req.wdata = t_link'(r_init_cnt) + t_link'(1);
                o_prev_req.we    = 1'b1;
                o_prev_req.waddr = r_init_cnt;
                o_prev_req.wdata = (r_init_cnt == '0) ? SENTINEL
                                                      : t_link'(r_init_cnt) - t_link'(1);
                n_init_cnt       = r_init_cnt + t_entry'(1);
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_entry = w_in_entry;
                    n_alloc = (i_opcode == OP_ALLOC);
                    n_skip  = w_in_skip;
                end
            end
            ST_UNLINK: begin
                if (i_prev_rdata != SENTINEL) begin
                    o_next_req.we    = 1'b1;
                    o_next_req.waddr = i_prev_rdata[ENTRY_W-1:0];
                    o_next_req.wdata = i_next_rdata;
                    if (i_next_rdata == SENTINEL) begin
                        n_tail = i_prev_rdata;
                    end else begin
                        o_prev_req.we    = 1'b1;
                        o_prev_req.waddr = i_next_rdata[ENTRY_W-1:0];
                        o_prev_req.wdata = i_prev_rdata;
                    end
                end
            end
            ST_LINK: begin
                o_next_req.we    = 1'b1;
                o_next_req.waddr = r_entry;
                o_next_req.wdata = r_head;
                o_prev_req.we    = 1'b1;
                o_prev_req.waddr = r_head[ENTRY_W-1:0];
                o_prev_req.wdata = t_link'(r_entry);
            end
            ST_FRONT: begin
                // idempotent, so repeating while the output is held is harmless
                if (!r_skip) begin
                    o_prev_req.we    = 1'b1;
                    o_prev_req.waddr = r_entry;
                    o_prev_req.wdata = SENTINEL;
                    n_head           = t_link'(r_entry);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_init_cnt <= '0;
            r_head     <= '0;
            r_tail     <= t_link'(ENTRIES - 1);
            r_alloc    <= 1'b0;
            r_skip     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init_cnt <= n_init_cnt;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_alloc    <= n_alloc;
            r_skip     <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_ctrl.valid = (r_state == ST_FRONT);
    assign o_ctrl.alloc = r_alloc;
    assign o_ctrl.front = r_skip ? to_front(r_head) : to_front(t_link'(r_entry));
    assign o_ctrl.head  = r_head;
    assign o_ctrl.tail  = r_tail;

endmodule

@@ rtl/core/lru_list_pool_manager.sv @@
// ----------------------------------------------------------------------------
// lru_list_pool_manager
// LRU pool manager: doubly linked MRU list in two link memories.
// ----------------------------------------------------------------------------
// After reset the block runs a fill pass over all ENTRIES entries (1024) that
// writes the initial chain into the next and prev link memories; no
// transaction is accepted until it ends. For each touch or alloc, the cycle
// in which it is accepted reads the entry's links, then the unlink, link and
// front states write the links in turn, as the single write port of the prev
// link memory takes up to three updates per move. The result is loaded into
// the output register as the sequencer leaves its front state, and the
// sequencer then returns to idle for the next transaction. A touch of the
// entry already at the front skips the link state, and a touch of an index
// beyond the pool goes straight to the front state. A stalled output holds
// the sequencer in its front state. The head and tail of the list are held
// in registers. A new transaction may be accepted while the previous result
// waits on the output.
// ----------------------------------------------------------------------------
module lru_list_pool_manager (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [lru_pkg::IDX_W-1:0]   i_entry_index,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lru_pkg::FRONT_W-1:0] o_front_index,
    output logic [lru_pkg::COUNT_W-1:0] o_alloc_total
);
    import lru_pkg::*;

    t_ctrl_out w_ctrl;
    t_ram_req  w_next_req;
    t_ram_req  w_prev_req;
    t_link     w_next_rdata;
    t_link     w_prev_rdata;
    logic      w_out_free;

    logic               r_out_valid;
    logic [FRONT_W-1:0] r_front;
    logic [COUNT_W-1:0] r_alloc_count;

    assign w_out_free = !r_out_valid || i_out_ready;

    lru_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .o_in_ready    (o_in_ready),
        .i_out_free    (w_out_free),
        .o_ctrl        (w_ctrl),
        .o_next_req    (w_next_req),
        .o_prev_req    (w_prev_req),
        .i_next_rdata  (w_next_rdata),
        .i_prev_rdata  (w_prev_rdata)
    );

    lru_link_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (LINK_W)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_req.we),
        .i_waddr (w_next_req.waddr),
        .i_wdata (w_next_req.wdata),
        .i_raddr (w_next_req.raddr),
        .o_rdata (w_next_rdata)
    );

    lru_link_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (LINK_W)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prev_req.we),
        .i_waddr (w_prev_req.waddr),
        .i_wdata (w_prev_req.wdata),
        .i_raddr (w_prev_req.raddr),
        .o_rdata (w_prev_rdata)
    );

    // output register; the allocation count is loaded with each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_alloc_count <= '0;
        end else if (w_ctrl.valid && w_out_free) begin
            r_out_valid   <= 1'b1;
            r_alloc_count <= r_alloc_count + COUNT_W'(w_ctrl.alloc);
        end else if (i_out_ready) begin
            r_out_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.valid && w_out_free) begin
            r_front <= w_ctrl.front;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_index = r_front;
    assign o_alloc_total = r_alloc_count;

    // one transaction in flight at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction accepted while one is in flight");

    // the counter only steps by one, and only when a result is loaded
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctrl.valid && w_out_free && w_ctrl.alloc) |=> $stable(r_alloc_count))
        else $error("allocation count changed without an alloc result");

    // the head and tail registers always name real entries
    a_ends_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.head != SENTINEL) && (w_ctrl.tail != SENTINEL))
        else $error("list end register holds the sentinel");

endmodule

@@ sim/tb_lru_list_pool_manager.sv @@
// ----------------------------------------------------------------------------
// tb_lru_list_pool_manager
// Self-checking bench for the LRU list pool manager. A shadow copy of the
// MRU list and the allocation counter is updated on every accepted
// transaction. Each result is checked against the oldest prediction. The
// stimulus is a directed opening, then a random mix of touches and allocs,
// with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_lru_list_pool_manager;
    timeunit 1ns;
    timeprecision 1ps;

    import lru_pkg::*;

    localparam int RANDOM_OPS  = 1730;
    localparam int IDLE_PCT    = 14;
    localparam int CALM_FIRST  = 700;
    localparam int CALM_LAST   = 1000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic             opcode;
        logic [IDX_W-1:0] idx;
    } t_lru_op;

    typedef struct {
        logic [FRONT_W-1:0] front;
        logic [COUNT_W-1:0] total;
    } t_lru_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_opcode = OP_TOUCH;
    logic [IDX_W-1:0]   i_entry_index = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [FRONT_W-1:0] o_front_index;
    logic [COUNT_W-1:0] o_alloc_total;

    // shadow of the list, sentinel at index ENTRIES
    t_link              nxt_link [ENTRIES+1];
    t_link              prv_link [ENTRIES+1];
    logic [COUNT_W-1:0] allocs_done;

    t_lru_op            pending_ops[$];
    t_lru_result        due_results[$];
    int                 ops_total;
    int                 ops_accepted = 0;
    int                 results_seen = 0;
    bit                 mismatch_seen = 1'b0;

    lru_list_pool_manager uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_front_index (o_front_index),
        .o_alloc_total (o_alloc_total)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void move_to_front(input t_link e);
        t_link nx;
        t_link pv;
        t_link first;
        nx = nxt_link[e];
        pv = prv_link[e];
        prv_link[nx] = pv;
        nxt_link[pv] = nx;
        first = nxt_link[SENTINEL];
        nxt_link[e] = first;
        prv_link[first] = e;
        prv_link[e] = SENTINEL;
        nxt_link[SENTINEL] = e;
    endfunction

    function automatic void apply_lru_op(input logic opcode, input logic [IDX_W-1:0] idx);
        t_link       tail;
        t_lru_result res;
        if (opcode == OP_ALLOC) begin
            tail = prv_link[SENTINEL];
            if (int'(tail) < ENTRIES) begin
                move_to_front(tail);
            end
            allocs_done = allocs_done + 1'b1;
        end else if (int'(idx) < ENTRIES) begin
            move_to_front(t_link'(idx));
        end
        res.front = nxt_link[SENTINEL][FRONT_W-1:0];
        res.total = allocs_done;
        due_results.push_back(res);
    endfunction

    function automatic void queue_op(input logic opcode, input int idx);
        t_lru_op op;
        op.opcode = opcode;
        op.idx    = IDX_W'(idx);
        pending_ops.push_back(op);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                apply_lru_op(i_opcode, i_entry_index);
                ops_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_ops.size() != 0 &&
                    ((ops_accepted >= CALM_FIRST && ops_accepted < CALM_LAST) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_valid    <= 1'b1;
                    i_opcode      <= pending_ops[0].opcode;
                    i_entry_index <= pending_ops[0].idx;
                    void'(pending_ops.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $error("result with no transaction outstanding: front_index %0d, alloc_total %0d",
                           o_front_index, o_alloc_total);
                    mismatch_seen = 1'b1;
                end else begin
                    if (o_front_index !== due_results[0].front) begin
                        $error("front_index: expected %0d, got %0d",
                               due_results[0].front, o_front_index);
                        mismatch_seen = 1'b1;
                    end
                    if (o_alloc_total !== due_results[0].total) begin
                        $error("alloc_total: expected %0d, got %0d",
                               due_results[0].total, o_alloc_total);
                        mismatch_seen = 1'b1;
                    end
                    void'(due_results.pop_front());
                end
                results_seen++;
            end
            i_out_ready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                           ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        int r;
        int sel;
        int last_touch;

        for (int i = 0; i < ENTRIES; i++) begin
            nxt_link[i] = t_link'(i + 1);
            prv_link[i] = (i == 0) ? SENTINEL : t_link'(i - 1);
        end
        nxt_link[SENTINEL] = '0;
        prv_link[SENTINEL] = t_link'(ENTRIES - 1);
        allocs_done = '0;

        // directed opening
        queue_op(OP_TOUCH, ENTRIES - 1);   // tail straight to the front
        queue_op(OP_TOUCH, ENTRIES - 1);   // front touched again: no change
        queue_op(OP_TOUCH, 0);             // old front, now second
        queue_op(OP_ALLOC, 1023);          // index ignored on alloc
        queue_op(OP_ALLOC, 0);
        queue_op(OP_TOUCH, 1021);
        queue_op(OP_TOUCH, 1022);
        queue_op(OP_TOUCH, 341);
        queue_op(OP_TOUCH, 682);
        queue_op(OP_TOUCH, 512);
        queue_op(OP_TOUCH, 1);
        queue_op(OP_ALLOC, 682);
        queue_op(OP_ALLOC, 341);
        queue_op(OP_TOUCH, 1018);          // current tail
        queue_op(OP_ALLOC, 1023);
        queue_op(OP_ALLOC, 512);
        queue_op(OP_TOUCH, 2);
        queue_op(OP_TOUCH, 2);
        queue_op(OP_ALLOC, 1);
        queue_op(OP_TOUCH, 1023);
        queue_op(OP_ALLOC, 0);

        last_touch = 0;
        for (int k = 0; k < RANDOM_OPS; k++) begin
            r = $urandom_range(99);
            if (r < 40) begin
                queue_op(OP_ALLOC, $urandom_range(1023));
            end else if (r < 60) begin
                // small hot set near both ends of the reset order
                sel = $urandom_range(7);
                last_touch = (sel < 4) ? sel : ENTRIES - 8 + sel;
                queue_op(OP_TOUCH, last_touch);
            end else if (r < 70) begin
                queue_op(OP_TOUCH, last_touch);
            end else begin
                last_touch = $urandom_range(1023);
                queue_op(OP_TOUCH, last_touch);
            end
        end
        ops_total = pending_ops.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted < ops_total) @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (!mismatch_seen) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
